FILE: rtl/lru_page_replacement_macros.svh
// Assertion macros used by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lrupr_pkg.sv
// Package with the constants of the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

	// Default sizes of the frame set and of the stored page numbers.
	localparam int FRAMES_DEFAULT    = 8;
	localparam int PAGE_BITS_DEFAULT = 16;

	// Fixed widths of the item fields.
	localparam int PAGE_FIELD_W  = 16;
	localparam int INDEX_FIELD_W = 3;
	localparam int COUNT_W       = 32;

	// Frame count register.
	localparam int                CFG_W               = 4;
	localparam logic [CFG_W-1:0]  FRAMES_IN_USE_RESET = 4'd8;

	// APB port and register map.
	localparam int   APB_ADDR_W        = 3;
	localparam int   APB_DATA_W        = 32;
	localparam logic REG_FRAMES_IN_USE = 1'b0;

endpackage

FILE: rtl/lru_page_replacement.sv
// LRU page replacement: one page reference per item, one result per item.
// An accepted item enters the input register; its result is written to the result register
// once that register is free, and is offered from there.
// Throughput: one item per cycle unless out_ready holds the result register; the rate is set
// by the combinational tag match and rank update over all frames between the two registers.
// Reset: all frames empty, ranks and fault count zero, frame count register at 8.
`timescale 1ns / 1ps
`include "lru_page_replacement_macros.svh"

module lru_page_replacement
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEFAULT,
	parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// APB configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]    prdata,
	output logic                     pready,
	// Reference input
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PAGE_FIELD_W-1:0]  page_number,
	// Result output
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic [INDEX_FIELD_W-1:0] frame_index,
	output logic                     evicted_valid,
	output logic [PAGE_FIELD_W-1:0]  evicted_page,
	output logic [COUNT_W-1:0]       fault_count
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RW = IW;
	localparam int PW = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;

	// Configuration and frame state.
	logic [CFG_W-1:0]   fiu_q;
	logic [PW-1:0]      pages_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	logic [RW-1:0]      rank_q  [FRAMES];
	logic [COUNT_W-1:0] faults_q;

	// Input register and result register.
	logic                     valid_s1;
	logic [PW-1:0]            page_s1;
	logic                     res_valid_s2;
	logic                     hit_s2;
	logic [INDEX_FIELD_W-1:0] index_s2;
	logic                     ev_valid_s2;
	logic [PAGE_FIELD_W-1:0]  ev_page_s2;
	logic [COUNT_W-1:0]       count_s2;

	// Handshake and configuration strobes.
	logic res_free;
	logic adv;
	logic cfg_wr;

	// Combinational lookup and update.
	logic [FRAMES-1:0]  in_use;
	logic [FRAMES-1:0]  hit_vec;
	logic [FRAMES-1:0]  empty_vec;
	logic [FRAMES-1:0]  vic_vec;
	logic [RW-1:0]      last_rank;
	logic [CFG_W-1:0]   fiu_m1;
	logic               hit_any;
	logic               found;
	logic [IW-1:0]      hit_idx;
	logic [IW-1:0]      empty_idx;
	logic [IW-1:0]      vic_idx;
	logic [IW-1:0]      k_idx;
	logic [RW-1:0]      rank_k;
	logic               fill;
	logic               replace;
	logic [RW-1:0]      rank_d  [FRAMES];
	logic [COUNT_W-1:0] faults_d;
	logic [IW+2:0]      k_ext;
	logic [PW+15:0]     ev_ext;

	// Handshake: the input register moves on whenever the result register can take its item.
	assign res_free = !res_valid_s2 || out_ready;
	assign adv      = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	// APB: always ready, one register at the bottom of the map.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES_IN_USE);
	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ?
		{{(APB_DATA_W-CFG_W){1'b0}}, fiu_q} : '0;

	// Frame count register, with the rank of the least recent frame when all are full.
	assign fiu_m1 = fiu_q - 4'd1;
	always_comb begin
		if (fiu_q == '0) begin
			last_rank = '0;
		end else if (32'(fiu_q) >= FRAMES) begin
			last_rank = RW'(FRAMES - 1);
		end else begin
			last_rank = RW'(fiu_m1);
		end
	end

	// Per-frame match, empty and victim flags, and the lowest index of each.
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		vic_idx   = '0;
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i]    = (i == 0) || (32'(i) < 32'(fiu_q));
			hit_vec[i]   = in_use[i] && valid_q[i] && (pages_q[i] == page_s1);
			empty_vec[i] = in_use[i] && !valid_q[i];
			vic_vec[i]   = in_use[i] && valid_q[i] && (rank_q[i] == last_rank);
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IW'(i);
			end
			if (empty_vec[i]) begin
				empty_idx = IW'(i);
			end
			if (vic_vec[i]) begin
				vic_idx = IW'(i);
			end
		end
		hit_any = |hit_vec;
		found   = |empty_vec;
	end

	// Choose the frame that takes the reference and age the frames more recent than it (all valid frames on a fill).
	always_comb begin
		fill    = !hit_any && found;
		replace = !hit_any && !found;
		if (hit_any) begin
			k_idx = hit_idx;
		end else if (found) begin
			k_idx = empty_idx;
		end else begin
			k_idx = vic_idx;
		end
		rank_k = rank_q[k_idx];
		for (int i = 0; i < FRAMES; i++) begin
			rank_d[i] = rank_q[i];
			if (IW'(i) == k_idx) begin
				rank_d[i] = '0;
			end else if (in_use[i] && valid_q[i] && (fill || (rank_q[i] < rank_k)) &&
				(rank_q[i] != RW'(FRAMES - 1))) begin
				rank_d[i] = rank_q[i] + RW'(1);
			end
		end
		if (!hit_any && (faults_q != '1)) begin
			faults_d = faults_q + COUNT_W'(1);
		end else begin
			faults_d = faults_q;
		end
		k_ext  = {3'b000, k_idx};
		ev_ext = {16'h0000, pages_q[k_idx]};
	end

	// Control state: frame count, valid marks, ranks, fault counter and both handshakes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q        <= FRAMES_IN_USE_RESET;
			valid_q      <= '0;
			faults_q     <= '0;
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (res_free) begin
				res_valid_s2 <= valid_s1;
			end
			if (adv) begin
				faults_q <= faults_d;
				if (fill) begin
					valid_q[k_idx] <= 1'b1;
				end
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= rank_d[i];
				end
			end
			// A write to the frame count flushes every frame.
			if (cfg_wr) begin
				fiu_q   <= pwdata[CFG_W-1:0];
				valid_q <= '0;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= '0;
				end
			end
		end
	end

	// Payload registers: page store, input page and result fields.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_s1 <= page_number[PW-1:0];
		end
		if (adv) begin
			if (!hit_any) begin
				pages_q[k_idx] <= page_s1;
			end
			hit_s2      <= hit_any;
			index_s2    <= k_ext[INDEX_FIELD_W-1:0];
			ev_valid_s2 <= replace;
			ev_page_s2  <= replace ? ev_ext[PAGE_FIELD_W-1:0] : '0;
			count_s2    <= faults_d;
		end
	end

	// Result ports come straight from the result register.
	assign out_valid     = res_valid_s2;
	assign hit           = hit_s2;
	assign frame_index   = index_s2;
	assign evicted_valid = ev_valid_s2;
	assign evicted_page  = ev_page_s2;
	assign fault_count   = count_s2;

	// When every frame in use is full, exactly one of them holds the oldest rank.
	`LRUPR_ASSERT_NOW(a_single_victim, valid_s1 && !hit_any && !found, $onehot(vic_vec), "no unique LRU victim among full frames")
	// Resident pages are distinct, so a reference matches at most one frame.
	`LRUPR_ASSERT_NOW(a_single_match, valid_s1, $onehot0(hit_vec), "page resident in more than one frame")
	// Every fault below saturation advances the counter by one.
	`LRUPR_ASSERT_NEXT(a_fault_count, adv && !hit_any && (faults_q != '1), faults_q == $past(faults_q) + 32'd1, "fault counter did not advance on a fault")

endmodule
